FILE: rtl/aets_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// aets_pkg
// Shared types for the aging exit status table.
// -----------------------------------------------------------------------------
package aets_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_FIND   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    REG_SIZE_LIMIT = 1'd0,
    REG_AGE_LIMIT  = 1'd1
  } reg_e;

  typedef struct packed {
    op_e         opcode;
    logic [21:0] proc_id;
    logic [15:0] status_in;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [15:0] status_out;
    logic        absent_error;
    logic [6:0]  occupancy;
  } out_item_t;

  typedef struct packed {
    logic [21:0] key;
    logic [15:0] status;
    logic [31:0] stamp;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  localparam logic [6:0]  SizeLimitRst = 7'd64;
  localparam logic [31:0] AgeLimitRst  = 32'd1000;

endpackage

FILE: rtl/aets_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// aets_ram
// Generic single write, single read RAM with registered read data.
// -----------------------------------------------------------------------------
module aets_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/aging_exit_status_table_unit.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// aging_exit_status_table_unit
// Keyed table of exit records with size and age based eviction.
// -----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i/in_ready_o carries one item: opcode, proc_id,
//   status_in. Output channel out_valid_o/out_ready_i returns one item per
//   input item: found, status_out, absent_error, occupancy.
//   Records live in one RAM (key, status, stamp); valid bits sit in flops.
//   Each item runs one serial scan of the RAM, one entry per cycle, behind
//   the registered read port; find, remove and tick finish after that scan.
//   An add then writes its record and checks the size limit, with one
//   rescan of the RAM for every record it must evict to get under it.
//   in_ready_o is high only while the scanner is free; a new item may be
//   taken while the previous result still waits in the output register.
//   If the receiver stalls, the finished result holds the block until the
//   output register drains.
//   Reset clears all valid bits, the record count and time at once; no
//   clearing pass is needed. Config writes (cfg_we_i) are taken any cycle
//   and must only happen while idle.
// -----------------------------------------------------------------------------
module aging_exit_status_table_unit #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aets_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output aets_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_index_i,
  input  logic [31:0]         cfg_wdata_i
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_ADD   = 6'b000100,
    ST_CHECK = 6'b001000,
    ST_EVICT = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [6:0]  size_limit_q;
  logic [31:0] age_limit_q;

  aets_pkg::op_e op_q, op_d;
  logic [21:0]   id_q, id_d;
  logic [15:0]   st_q, st_d;
  logic [31:0]   time_q, time_d;
  logic [CW-1:0] count_q, count_d;
  logic [ENTRIES-1:0] valid_q, valid_d;

  logic [AW:0]   cnt_q, cnt_d;
  logic          pvld_q, pvld_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic          ev_q, ev_d;

  logic          m_hit_q, m_hit_d;
  logic [AW-1:0] m_idx_q, m_idx_d;
  logic [15:0]   m_st_q, m_st_d;
  logic          f_hit_q, f_hit_d;
  logic [AW-1:0] f_idx_q, f_idx_d;
  logic          o_hit_q, o_hit_d;
  logic [AW-1:0] o_idx_q, o_idx_d;
  logic [31:0]   o_age_q, o_age_d;

  logic                out_valid_q, out_valid_d;
  aets_pkg::out_item_t out_q, out_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  aets_pkg::entry_t ram_wdata, ram_rdata;
  logic [31:0]     age;
  logic            ent_v;
  logic [31:0]     lim;
  logic            res_found;

  aets_ram #(
    .WIDTH(aets_pkg::EntryW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(cnt_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  assign age   = time_q - ram_rdata.stamp;
  assign ent_v = valid_q[pidx_q];
  assign lim   = (32'(size_limit_q) < ENTRIES) ? 32'(size_limit_q) : ENTRIES;
  assign res_found = m_hit_q &&
                     (op_q == aets_pkg::OP_FIND || op_q == aets_pkg::OP_REMOVE);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    id_d        = id_q;
    st_d        = st_q;
    time_d      = time_q;
    count_d     = count_q;
    valid_d     = valid_q;
    cnt_d       = cnt_q;
    pvld_d      = 1'b0;
    pidx_d      = pidx_q;
    ev_d        = ev_q;
    m_hit_d     = m_hit_q;
    m_idx_d     = m_idx_q;
    m_st_d      = m_st_q;
    f_hit_d     = f_hit_q;
    f_idx_d     = f_idx_q;
    o_hit_d     = o_hit_q;
    o_idx_d     = o_idx_q;
    o_age_d     = o_age_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = f_idx_q;
    ram_wdata   = '{key: id_q, status: st_q, stamp: time_q};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = in_item_i.opcode;
          id_d    = in_item_i.proc_id;
          st_d    = in_item_i.status_in;
          if (in_item_i.opcode == aets_pkg::OP_TICK) begin
            time_d = time_q + 32'd1;
          end
          ev_d    = 1'b0;
          cnt_d   = '0;
          m_hit_d = 1'b0;
          f_hit_d = 1'b0;
          o_hit_d = 1'b0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q < (AW+1)'(ENTRIES)) begin
          pvld_d = 1'b1;
          pidx_d = cnt_q[AW-1:0];
          cnt_d  = cnt_q + 1'b1;
        end
        if (pvld_q) begin
          if (ent_v && ram_rdata.key == id_q && !m_hit_q) begin
            m_hit_d = 1'b1;
            m_idx_d = pidx_q;
            m_st_d  = ram_rdata.status;
          end
          if (!ent_v && !f_hit_q) begin
            f_hit_d = 1'b1;
            f_idx_d = pidx_q;
          end
          if (ent_v && (!o_hit_q || age > o_age_q)) begin
            o_hit_d = 1'b1;
            o_idx_d = pidx_q;
            o_age_d = age;
          end
          if (op_q == aets_pkg::OP_TICK && ent_v && age >= age_limit_q) begin
            valid_d[pidx_q] = 1'b0;
            count_d = count_q - 1'b1;
          end
          if (pidx_q == AW'(ENTRIES - 1)) begin
            if (ev_q) begin
              state_d = ST_EVICT;
            end else begin
              case (op_q)
                aets_pkg::OP_ADD: state_d = ST_ADD;
                aets_pkg::OP_REMOVE: begin
                  if (m_hit_d) begin
                    valid_d[m_idx_d] = 1'b0;
                    count_d          = count_q - 1'b1;
                  end
                  state_d = ST_DONE;
                end
                default: state_d = ST_DONE;
              endcase
            end
          end
        end
      end
      ST_ADD: begin
        ram_we = 1'b1;
        if (m_hit_q) begin
          ram_waddr = m_idx_q;
        end else if (32'(count_q) >= ENTRIES) begin
          ram_waddr = o_idx_q;
        end else begin
          ram_waddr          = f_idx_q;
          valid_d[f_idx_q]   = 1'b1;
          count_d            = count_q + 1'b1;
        end
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (32'(count_q) > lim) begin
          ev_d    = 1'b1;
          cnt_d   = '0;
          o_hit_d = 1'b0;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_EVICT: begin
        if (o_hit_q) begin
          valid_d[o_idx_q] = 1'b0;
          count_d          = count_q - 1'b1;
          state_d          = ST_CHECK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d        = 1'b1;
          out_d.found        = res_found;
          out_d.status_out   = res_found ? m_st_q : 16'd0;
          out_d.absent_error = (op_q == aets_pkg::OP_REMOVE) && !m_hit_q;
          out_d.occupancy    = 7'(count_q);
          state_d            = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      time_q       <= '0;
      count_q      <= '0;
      valid_q      <= '0;
      out_valid_q  <= 1'b0;
      pvld_q       <= 1'b0;
      size_limit_q <= aets_pkg::SizeLimitRst;
      age_limit_q  <= aets_pkg::AgeLimitRst;
    end else begin
      state_q     <= state_d;
      time_q      <= time_d;
      count_q     <= count_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      pvld_q      <= pvld_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          aets_pkg::REG_SIZE_LIMIT: size_limit_q <= cfg_wdata_i[6:0];
          aets_pkg::REG_AGE_LIMIT:  age_limit_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    id_q    <= id_d;
    st_q    <= st_d;
    cnt_q   <= cnt_d;
    pidx_q  <= pidx_d;
    ev_q    <= ev_d;
    m_hit_q <= m_hit_d;
    m_idx_q <= m_idx_d;
    m_st_q  <= m_st_d;
    f_hit_q <= f_hit_d;
    f_idx_q <= f_idx_d;
    o_hit_q <= o_hit_d;
    o_idx_q <= o_idx_d;
    o_age_q <= o_age_d;
    out_q   <= out_d;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: rtl/aets_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// aets_checker
// Port level checks for the aging exit status table.
// -----------------------------------------------------------------------------
module aets_checker #(
  parameter int unsigned ENTRIES = 64
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input aets_pkg::out_item_t out_item_o
);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready after accept");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled item changed");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.found && out_item_o.absent_error))
    else $error("found and absent together");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |-> out_item_o.status_out == 16'd0)
    else $error("status without match");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ENTRIES < 128 |-> 32'(out_item_o.occupancy) <= ENTRIES)
    else $error("occupancy beyond capacity");

endmodule

bind aging_exit_status_table_unit aets_checker #(.ENTRIES(ENTRIES)) u_aets_checker (.*);
